### src/resampling_sample_player_top_macros.svh
// ----------------------------------------------------------------------------
// resampling sample player assertion macros
// property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef RESAMPLING_SAMPLE_PLAYER_TOP_MACROS_SVH
`define RESAMPLING_SAMPLE_PLAYER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define RSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsp check failed: same-cycle rule");

// next-cycle implication, off during reset
`define RSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsp check failed: next-cycle rule");

// next-cycle implication that also watches reset itself
`define RSP_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rsp check failed: reset rule");

`endif

### src/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// shared types and constants of the resampling sample player
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 17;
  localparam int STEP_W  = 36;
  localparam int POS_W   = 50;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = POS_W - 32;
  localparam int PROD_W  = 2 * (VAL_W + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RATE  = 3'd4;

  localparam int REQ_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;
  localparam int RES_CNT_W   = $clog2(RES_Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_START,
    OP_TICK,
    OP_STOP,
    OP_RATE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [ADDR_W-1:0]        addr;
    logic signed [VAL_W-1:0]  value;
    logic [LEN_W-1:0]         length;
    logic [STEP_W-1:0]        step;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] audio;
    logic                    still;
  } res_t;

endpackage

`default_nettype wire

### src/rsp_queue.sv
// ----------------------------------------------------------------------------
// rsp_queue
// small first-in first-out queue with valid/ready on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push_valid,
  output logic                                push_ready,
  input  wire logic [WIDTH-1:0]               push_data,
  output logic                                pop_valid,
  input  wire logic                           pop_ready,
  output logic [WIDTH-1:0]                    pop_data,
  output logic [$clog2(DEPTH+1)-1:0]          count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// takes requests, decodes the command, saturates the length and drops unknown commands and out-of-range loads
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_front
  import rsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic [CMD_W-1:0]         command,
  input  wire logic [ADDR_W-1:0]        word_address,
  input  wire logic signed [VAL_W-1:0]  word_value,
  input  wire logic [LEN_W-1:0]         sample_length,
  input  wire logic [STEP_W-1:0]        rate_step,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output req_t                          push_req
);

  logic             addr_ok;
  logic [LEN_W-1:0] len_sat;

  assign req_ready = push_ready;
  assign addr_ok   = 32'(word_address) < 32'(SAMPLE_DEPTH);
  assign len_sat   = (32'(sample_length) > 32'(SAMPLE_DEPTH)) ?
                     LEN_W'(SAMPLE_DEPTH) : sample_length;

  always_comb begin
    push_req.op     = OP_LOAD;
    push_req.addr   = word_address;
    push_req.value  = word_value;
    push_req.length = len_sat;
    push_req.step   = rate_step;
    push_valid      = 1'b0;
    unique case (command)
      CMD_LOAD: begin
        push_req.op = OP_LOAD;
        // loads past the end of memory are dropped here
        push_valid  = req_valid && addr_ok;
      end
      CMD_START: begin
        push_req.op = OP_START;
        push_valid  = req_valid;
      end
      CMD_TICK: begin
        push_req.op = OP_TICK;
        push_valid  = req_valid;
      end
      CMD_STOP: begin
        push_req.op = OP_STOP;
        push_valid  = req_valid;
      end
      CMD_RATE: begin
        push_req.op = OP_RATE;
        push_valid  = req_valid;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// playback state, sample memory and the interpolation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_back
  import rsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire req_t                  req,
  input  wire logic [RES_CNT_W-1:0]  res_count,
  output logic                       res_valid,
  output res_t                       res
);

  localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  // playback state
  logic [POS_W-1:0]  position;
  logic [STEP_W-1:0] step;
  logic [LEN_W-1:0]  valid_count;
  logic              active;

  // sample memory, single port
  logic signed [VAL_W-1:0] mem [SAMPLE_DEPTH];
  logic signed [VAL_W-1:0] mem_rdata;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we;

  // stage 1: second read issued
  logic              p1_valid;
  logic              p1_zero;
  logic              p1_still;
  logic [FRAC_W-1:0] p1_frac;
  logic [AW-1:0]     p1_addr_b;
  // stage 2: both samples available
  logic                    p2_valid;
  logic                    p2_zero;
  logic                    p2_still;
  logic [FRAC_W-1:0]       p2_frac;
  logic signed [VAL_W-1:0] a_q;
  // stage 3: product registered
  logic                    p3_valid;
  logic                    p3_zero;
  logic                    p3_still;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [VAL_W-1:0]  a_q2;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        last;
  logic [POS_W-1:0]        pos_adv;
  logic                    playing;
  logic                    adv_end;
  logic                    credit_ok;
  logic                    pop;
  logic signed [VAL_W:0]   diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W+1:0] sum;

  assign idx     = position[POS_W-1:32];
  assign last    = IDX_W'(valid_count) - IDX_W'(1);
  assign pos_adv = position + POS_W'(step);
  assign playing = active && (valid_count >= LEN_W'(2)) && (idx < last);
  assign adv_end = pos_adv[POS_W-1:32] >= last;

  // every tick holds a result slot from pop until it leaves the queue
  assign credit_ok = ($countones({p1_valid, p2_valid, p3_valid}) + int'(res_count))
                     < RES_Q_DEPTH;
  assign pop       = req_valid && !p1_valid && ((req.op != OP_TICK) || credit_ok);
  assign req_ready = pop;

  assign mem_we   = pop && (req.op == OP_LOAD);
  assign mem_addr = mem_we ? AW'(req.addr) : (p1_valid ? p1_addr_b : AW'(idx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= req.value;
    end else begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      step        <= '0;
      valid_count <= '0;
      active      <= 1'b0;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
      p3_valid    <= 1'b0;
    end else begin
      p1_valid <= pop && (req.op == OP_TICK);
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      if (pop) begin
        unique case (req.op)
          OP_LOAD: begin
          end
          OP_START: begin
            valid_count <= req.length;
            step        <= req.step;
            position    <= '0;
            active      <= (req.length >= LEN_W'(2));
          end
          OP_TICK: begin
            if (playing) begin
              position <= pos_adv;
              active   <= !adv_end;
            end else begin
              active <= 1'b0;
            end
          end
          OP_STOP: begin
            active <= 1'b0;
          end
          OP_RATE: begin
            step <= req.step;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign diff = {mem_rdata[VAL_W-1], mem_rdata} - {a_q[VAL_W-1], a_q};
  assign prod = diff * $signed({1'b0, p2_frac});
  // arithmetic shift by 16 gives the floor
  assign sum  = {{2{a_q2[VAL_W-1]}}, a_q2} + prod_q[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_zero   <= !playing;
      p1_still  <= playing && !adv_end;
      p1_frac   <= position[31:16];
      p1_addr_b <= AW'(idx + IDX_W'(1));
    end
    p2_zero  <= p1_zero;
    p2_still <= p1_still;
    p2_frac  <= p1_frac;
    a_q      <= mem_rdata;
    p3_zero  <= p2_zero;
    p3_still <= p2_still;
    prod_q   <= prod;
    a_q2     <= a_q;
  end

  assign res_valid = p3_valid;
  assign res.audio = p3_zero ? '0 : sum[VAL_W-1:0];
  assign res.still = p3_still;

endmodule

`default_nettype wire

### src/resampling_sample_player_top.sv
// ----------------------------------------------------------------------------
// resampling_sample_player_top
// linear interpolating playback of a stored 16-bit sample at a 4.32 step
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    command word_address word_value
//                                       sample_length rate_step
//  res      out  res_valid/res_ready    audio_out still_playing
//
//  a tick uses the single sample memory port for one read per neighbor, so no
//  request is taken until its second read is issued; a tick waits for a free
//  result slot, and its result passes the pipeline and the result queue
//  rst clears playback state and both queues; sample memory is not cleared
//  requests buffer in a 2-entry queue; results in a 4-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module resampling_sample_player_top
  import rsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic [CMD_W-1:0]         command,
  input  wire logic [ADDR_W-1:0]        word_address,
  input  wire logic signed [VAL_W-1:0]  word_value,
  input  wire logic [LEN_W-1:0]         sample_length,
  input  wire logic [STEP_W-1:0]        rate_step,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output logic signed [VAL_W-1:0]       audio_out,
  output logic                          still_playing
);

  localparam int REQ_W = $bits(req_t);
  localparam int RES_W = $bits(res_t);

  logic                 front_valid;
  logic                 front_ready;
  req_t                 front_req;
  logic [REQ_W-1:0]     front_bits;
  logic                 back_valid;
  logic                 back_ready;
  logic [REQ_W-1:0]     back_bits;
  req_t                 back_req;
  logic                 pipe_valid;
  res_t                 pipe_res;
  logic [RES_W-1:0]     pipe_bits;
  logic [RES_W-1:0]     out_bits;
  res_t                 out_res;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push_ready;

  assign front_bits = front_req;
  assign back_req   = req_t'(back_bits);
  assign pipe_bits  = pipe_res;
  assign out_res    = res_t'(out_bits);

  assign audio_out     = out_res.audio;
  assign still_playing = out_res.still;

  rsp_front #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_front (
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .command       (command),
    .word_address  (word_address),
    .word_value    (word_value),
    .sample_length (sample_length),
    .rate_step     (rate_step),
    .push_valid    (front_valid),
    .push_ready    (front_ready),
    .push_req      (front_req)
  );

  rsp_queue #(
    .WIDTH (REQ_W),
    .DEPTH (REQ_Q_DEPTH)
  ) u_req_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_bits),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_bits),
    .count      ()
  );

  rsp_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (back_valid),
    .req_ready (back_ready),
    .req       (back_req),
    .res_count (res_count),
    .res_valid (pipe_valid),
    .res       (pipe_res)
  );

  // back end only issues a tick when a slot here is reserved
  rsp_queue #(
    .WIDTH (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (pipe_valid),
    .push_ready (res_push_ready),
    .push_data  (pipe_bits),
    .pop_valid  (res_valid),
    .pop_ready  (res_ready),
    .pop_data   (out_bits),
    .count      (res_count)
  );

endmodule

`default_nettype wire

### src/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// port-level checks of the resampling sample player, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "resampling_sample_player_top_macros.svh"

module rsp_checker
  import rsp_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    req_valid,
  input wire logic                    req_ready,
  input wire logic [CMD_W-1:0]        command,
  input wire logic                    res_valid,
  input wire logic                    res_ready,
  input wire logic signed [VAL_W-1:0] audio_out,
  input wire logic                    still_playing
);

  // ticks taken whose result has not yet been taken
  logic [3:0] pending;
  logic       tick_in;
  logic       res_out;

  assign tick_in = req_valid && req_ready && (command == CMD_TICK);
  assign res_out = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (tick_in && !res_out) begin
      pending <= pending + 4'd1;
    end else if (res_out && !tick_in) begin
      pending <= pending - 4'd1;
    end
  end

  `RSP_ASSERT_ALWAYS_NEXT(a_reset_empties_res, rst, !res_valid)
  `RSP_ASSERT_NOW(a_res_needs_tick, res_valid, pending != 4'd0)
  `RSP_ASSERT_NOW(a_pending_bounded, 1'b1, pending < 4'd8)
  `RSP_ASSERT_NEXT(a_audio_holds, res_valid && !res_ready, res_valid && $stable(audio_out))
  `RSP_ASSERT_NEXT(a_still_holds, res_valid && !res_ready, $stable(still_playing))

endmodule

bind resampling_sample_player_top rsp_checker u_rsp_checker (.*);

`default_nettype wire

### sim/tb_resampling_sample_player_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resampling_sample_player_top
// drives load, start, tick, stop, set-rate and unused command requests into the sample
// player, predicts every tick result from its own copy of the sample memory
// and playback position, and compares each result in order
// ----------------------------------------------------------------------------

module tb_resampling_sample_player_top;
  import rsp_pkg::*;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  logic                     clk;
  logic                     rst;
  logic                     req_valid;
  logic                     req_ready;
  logic [CMD_W-1:0]         command;
  logic [ADDR_W-1:0]        word_address;
  logic signed [VAL_W-1:0]  word_value;
  logic [LEN_W-1:0]         sample_length;
  logic [STEP_W-1:0]        rate_step;
  logic                     res_valid;
  logic                     res_ready;
  logic signed [VAL_W-1:0]  audio_out;
  logic                     still_playing;

  // shadow of the player
  logic signed [VAL_W-1:0]  sample_mem [SAMPLE_DEPTH];
  bit                       sample_loaded [SAMPLE_DEPTH];
  logic [POS_W-1:0]         play_pos;
  logic [STEP_W-1:0]        play_rate;
  logic [LEN_W-1:0]         play_len;
  logic                     playing;
  res_t                     expected_audio [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          requests_sent;
  int          mismatch_count;
  int unsigned cycle_count;

  resampling_sample_player_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .command       (command),
    .word_address  (word_address),
    .word_value    (word_value),
    .sample_length (sample_length),
    .rate_step     (rate_step),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .audio_out     (audio_out),
    .still_playing (still_playing)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_audio.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got audio %0d still %0b",
                 $time, audio_out, still_playing);
      end else begin
        want = expected_audio.pop_front();
        if (audio_out !== want.audio) begin
          mismatch_count++;
          $display("%0t: audio_out expected %0d, got %0d", $time, want.audio, audio_out);
        end
        if (still_playing !== want.still) begin
          mismatch_count++;
          $display("%0t: still_playing expected %0b, got %0b",
                   $time, want.still, still_playing);
        end
      end
    end
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // applies one accepted request to the shadow, queues the tick result
  function automatic void advance_player(input logic [CMD_W-1:0] cmd,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [VAL_W-1:0] value,
                                         input logic [LEN_W-1:0] len,
                                         input logic [STEP_W-1:0] rate);
    res_t             r;
    logic [LEN_W-1:0] last;
    logic [IDX_W-1:0] idx;
    longint           a;
    longint           b;
    longint           prod;
    case (cmd)
      CMD_LOAD: begin
        sample_mem[addr] = value;
        sample_loaded[addr] = 1'b1;
      end
      CMD_START: begin
        play_len = (len > LEN_W'(SAMPLE_DEPTH)) ? LEN_W'(SAMPLE_DEPTH) : len;
        play_rate = rate;
        play_pos = '0;
        playing = (play_len >= 2);
      end
      CMD_STOP: playing = 1'b0;
      CMD_RATE: play_rate = rate;
      CMD_TICK: begin
        r.audio = '0;
        r.still = 1'b0;
        last = play_len - 1;
        idx = play_pos[POS_W-1:32];
        if (!playing || play_len < 2 || idx >= last) begin
          playing = 1'b0;
        end else begin
          a = longint'(sample_mem[idx[ADDR_W-1:0]]);
          b = longint'(sample_mem[ADDR_W'(idx + 1)]);
          prod = (b - a) * longint'(play_pos[31:16]);
          // floor division by 65536
          r.audio = VAL_W'(a + (prod >>> 16));
          play_pos = play_pos + POS_W'(play_rate);
          if (play_pos[POS_W-1:32] >= last)
            playing = 1'b0;
          r.still = playing;
        end
        expected_audio.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_rate();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {4'($urandom), 32'($urandom)};
      3: return {4'd1, 32'($urandom_range(32'h0fff_ffff))};
      default: return {4'd0, 32'($urandom)};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(9))
      0: return LEN_W'($urandom_range(1));
      1: return LEN_W'($urandom_range(SAMPLE_DEPTH + 1, (1 << LEN_W) - 1));
      2: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(2, 48));
    endcase
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [ADDR_W-1:0] addr,
                              input logic [VAL_W-1:0] value,
                              input logic [LEN_W-1:0] len,
                              input logic [STEP_W-1:0] rate);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    command       <= cmd;
    word_address  <= addr;
    word_value    <= value;
    sample_length <= len;
    rate_step     <= rate;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    advance_player(cmd, addr, value, len, rate);
    requests_sent++;
  endtask

  // loads the two neighbors first if the next tick would read unwritten words
  task automatic play_tick();
    logic [IDX_W-1:0] idx;
    idx = play_pos[POS_W-1:32];
    if (playing && idx < play_len - 1) begin
      for (int k = 0; k < 2; k++)
        if (!sample_loaded[ADDR_W'(idx + k)])
          send_request(CMD_LOAD, ADDR_W'(idx + k), VAL_W'($urandom), LEN_W'($urandom),
                       rand_rate());
    end
    send_request(CMD_TICK, ADDR_W'($urandom), VAL_W'($urandom), LEN_W'($urandom),
                 rand_rate());
  endtask

  // idle ticks, short samples, stop and set rate while idle, unused commands
  task automatic test_idle_commands();
    send_request(CMD_TICK, '1, '1, '1, '1);
    send_request(CMD_STOP, '0, '0, '0, '0);
    send_request(CMD_RATE, '0, '0, '0, '1);
    for (int c = int'(CMD_RATE) + 1; c < (1 << CMD_W); c++)
      send_request(CMD_W'(c), ADDR_W'($urandom), VAL_W'($urandom), LEN_W'($urandom),
                   rand_rate());
    send_request(CMD_START, '0, '0, LEN_W'(1), {4'd1, 32'd0});
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_START, '0, '0, '0, {4'd1, 32'd0});
    send_request(CMD_TICK, '0, '0, '0, '0);
  endtask

  // full-scale neighbors, maximum fraction, rate change and stop mid-note
  task automatic test_interpolation();
    send_request(CMD_LOAD, ADDR_W'(0), 16'sh8000, '0, '0);
    send_request(CMD_LOAD, ADDR_W'(1), 16'sh7fff, '0, '0);
    send_request(CMD_LOAD, ADDR_W'(2), 16'sh8000, '0, '0);
    send_request(CMD_LOAD, ADDR_W'(3), 16'sh0000, '0, '0);
    send_request(CMD_START, '0, '0, LEN_W'(4), {4'd0, 32'hffff_ffff});
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_RATE, '0, '0, '0, {4'd0, 32'h8000_0000});
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_STOP, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0);
    // end reached on the first advance, then ticks past the end
    send_request(CMD_START, '0, '0, LEN_W'(3), {4'd2, 32'd0});
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0);
  endtask

  // length beyond the memory saturates; a few ticks at the top rate, then stop
  task automatic test_saturated_length();
    send_request(CMD_START, ADDR_W'($urandom), VAL_W'($urandom), '1, '1);
    for (int n = 0; n < 16; n++)
      play_tick();
    send_request(CMD_STOP, '0, '0, '0, '0);
    play_tick();
  endtask

  task automatic test_random_notes(input int count, input int idle_pct, input int stall_pct);
    int first;
    int pick;
    first = requests_sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (requests_sent - first < count) begin
      if (!playing && $urandom_range(3) != 0) begin
        send_request(CMD_START, ADDR_W'($urandom), VAL_W'($urandom), rand_length(),
                     rand_rate());
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          play_tick();
        end else if (pick < 80) begin
          send_request(CMD_LOAD,
                       ($urandom_range(3) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(63)),
                       VAL_W'($urandom), LEN_W'($urandom), rand_rate());
        end else if (pick < 87) begin
          send_request(CMD_RATE, ADDR_W'($urandom), VAL_W'($urandom), LEN_W'($urandom),
                       rand_rate());
        end else if (pick < 92) begin
          send_request(CMD_STOP, ADDR_W'($urandom), VAL_W'($urandom), LEN_W'($urandom),
                       rand_rate());
        end else if (pick < 97) begin
          send_request(CMD_START, ADDR_W'($urandom), VAL_W'($urandom), rand_length(),
                       rand_rate());
        end else begin
          send_request(CMD_W'($urandom_range(int'(CMD_RATE) + 1, (1 << CMD_W) - 1)),
                       ADDR_W'($urandom), VAL_W'($urandom), LEN_W'($urandom), rand_rate());
        end
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req_valid      = 1'b0;
    command        = CMD_LOAD;
    word_address   = '0;
    word_value     = '0;
    sample_length  = '0;
    rate_step      = '0;
    res_ready      = 1'b0;
    play_pos       = '0;
    play_rate      = '0;
    play_len       = '0;
    playing        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    requests_sent  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_interpolation();
    test_saturated_length();
    test_random_notes(300, 0, 0);
    test_random_notes(300, 75, 0);
    test_random_notes(300, 0, 75);
    test_random_notes(300, 6, 6);

    req_valid <= 1'b0;
    while (expected_audio.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_audio.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
